[sv/critically_damped_vector_smoother_macros.svh]
// Assertion macros shared by the smoother modules.
`ifndef CRITICALLY_DAMPED_VECTOR_SMOOTHER_MACROS_SVH
`define CRITICALLY_DAMPED_VECTOR_SMOOTHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CDVS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CDVS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CDVS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CDVS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

[sv/cdvs_pkg.sv]
// Shared types, constants and helpers of the vector smoother.
package cdvs_pkg;
    localparam int FRAC_BITS = 16;
    localparam logic [1:0] REG_SMOOTH_TIME = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] REG_DELTA_TIME  = 2'd2;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint FLOOR_RAW = (ONE_Q + 5000) / 10000;
    localparam logic [30:0] FLOOR_T = (FLOOR_RAW < 1) ? 31'd1 : 31'(FLOOR_RAW);
    localparam logic [31:0] EPS_Q = 32'((ONE_Q + 50000) / 100000);
    localparam logic [31:0] C048 = 32'((48 * ONE_Q + 50) / 100);
    localparam logic [31:0] C0235 = 32'((235 * ONE_Q + 500) / 1000);
    localparam logic [31:0] ONE_C = 32'(ONE_Q);

    typedef enum logic [4:0] {
        ST_IDLE, ST_OMEGA, ST_X, ST_X2, ST_X3, ST_DEN1, ST_DEN2, ST_EXP,
        ST_CHG, ST_SQ, ST_MC, ST_MC2, ST_CMP, ST_SQRT, ST_CLAMP,
        ST_T1, ST_T2, ST_V1, ST_V2, ST_R1, ST_R2, ST_NEXTC, ST_DOT, ST_FIN, ST_OUT
    } state_t;

    typedef enum logic [1:0] {DIV_NONE, DIV_OMEGA, DIV_EXP, DIV_CLAMP} div_sel_t;

    typedef struct packed {
        state_t   state;
        logic [1:0] comp;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     load;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic need_clamp;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [31:0] ma, mb;
        logic [63:0] p, r;
        logic neg;
        ma = a[31] ? 32'(-a) : a;
        mb = b[31] ? 32'(-b) : b;
        p = 64'(ma) * 64'(mb);
        r = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        neg = a[31] ^ b[31];
        if (neg) return (r >= 64'h80000000) ? 32'sh80000000 : 32'(-r);
        return (r > 64'h7fffffff) ? 32'sh7fffffff : r[31:0];
    endfunction
endpackage

[sv/cdvs_div.sv]
// Restoring divider, one quotient bit per cycle.
module cdvs_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [95:0]  num,
    input  logic [63:0]  den,
    output logic         done,
    output logic [95:0]  quo
);
    import cdvs_pkg::*;
    logic [95:0] q_reg, q_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [64:0] sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        sh = {rem_reg[63:0], q_reg[95]};
        if (start) begin
            q_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = 7'd96;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = sh - {1'b0, den_reg};
                q_next = {q_reg[94:0], 1'b1};
            end else begin
                rem_next = sh;
                q_next = {q_reg[94:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) busy_next = 1'b0;
        end
    end

    assign done = busy_reg && cnt_reg == 7'd1;
    assign quo = q_next;
endmodule

[sv/cdvs_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
module cdvs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [65:0] val,
    output logic        done,
    output logic [32:0] root
);
    import cdvs_pkg::*;
    logic [65:0] v_reg, v_next;
    logic [67:0] rem_reg, rem_next;
    logic [32:0] r_reg, r_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [67:0] trial, sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        v_reg <= v_next;
        rem_reg <= rem_next;
        r_reg <= r_next;
    end

    always_comb begin
        v_next = v_reg;
        rem_next = rem_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        sh = {rem_reg[65:0], v_reg[65:64]};
        trial = {33'd0, r_reg, 2'b01};
        if (start) begin
            v_next = val;
            rem_next = '0;
            r_next = '0;
            cnt_next = 6'd33;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = {v_reg[63:0], 2'b00};
            if (sh >= trial) begin
                rem_next = sh - trial;
                r_next = {r_reg[31:0], 1'b1};
            end else begin
                rem_next = sh;
                r_next = {r_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    assign done = busy_reg && cnt_reg == 6'd1;
    assign root = r_next;
endmodule

[sv/cdvs_datapath.sv]
// Datapath: registers, multipliers, divider and square root units.
module cdvs_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  cdvs_pkg::cmd_t     cmd,
    output cdvs_pkg::sts_t     sts,
    input  logic [191:0]       in_data,
    input  logic [30:0]        smooth_time,
    input  logic [30:0]        max_speed,
    input  logic [30:0]        delta_time,
    output logic [192:0]       res_data
);
    import cdvs_pkg::*;
    `include "critically_damped_vector_smoother_macros.svh"
    logic signed [31:0] cur_reg [3];
    logic signed [31:0] tgt_reg [3];
    logic signed [31:0] chg_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] nvel_reg [3];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] tmp_reg, a_reg, b_reg;
    logic signed [31:0] omega_reg, x_reg, x2_reg, x3_reg, den_reg, ex_reg, mc_reg;
    logic [30:0] st_reg;
    logic [65:0] sq_reg;
    logic [63:0] mc2_reg;
    logic [32:0] len_reg;
    logic [66:0] pos_reg, neg_reg;
    logic snap_reg;
    logic signed [32:0] ta, tb;
    logic [31:0] mta, mtb;
    logic [63:0] pab;
    logic [95:0] dnum, dquo;
    logic [63:0] dden;
    logic ddone, qdone;
    logic [32:0] qroot;
    logic [31:0] mch;
    logic [1:0] c;
    logic signed [31:0] d1;
    logic [30:0] st_fl;

    assign c = cmd.comp;
    assign st_fl = (smooth_time < FLOOR_T) ? FLOOR_T : smooth_time;
    assign mch = chg_reg[c][31] ? 32'(-chg_reg[c]) : chg_reg[c];

    always_comb begin
        unique case (cmd.div_sel)
            DIV_OMEGA: begin
                dnum = (96'd2 << (2 * FRAC_BITS)) + 96'(st_reg >> 1);
                dden = 64'(st_reg);
            end
            DIV_EXP: begin
                dnum = (96'd1 << (2 * FRAC_BITS)) + 96'(den_reg >>> 1);
                dden = 64'(den_reg);
            end
            DIV_CLAMP: begin
                dnum = 96'(64'(mch) * 64'(mc_reg));
                dden = 64'(len_reg);
            end
            default: begin
                dnum = '0;
                dden = 64'd1;
            end
        endcase
    end

    cdvs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(dnum), .den(dden), .done(ddone), .quo(dquo)
    );

    cdvs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.sqrt_start),
        .val(sq_reg), .done(qdone), .root(qroot)
    );

    assign ta = 33'(tgt_reg[c]) - 33'(cur_reg[c]);
    assign tb = 33'(res_reg[c]) - 33'(tgt_reg[c]);
    assign mta = ta[32] ? 32'(-ta) : ta[31:0];
    assign mtb = tb[32] ? 32'(-tb) : tb[31:0];
    assign pab = 64'(mta) * 64'(mtb);
    assign d1 = sat32(66'(cur_reg[c]) - 66'(tgt_reg[c]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) vel_reg[i] <= '0;
        end else if (cmd.commit) begin
            for (int i = 0; i < 3; i++) vel_reg[i] <= snap_reg ? 32'sd0 : nvel_reg[i];
        end
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                cur_reg[i] <= in_data[32*i +: 32];
                tgt_reg[i] <= in_data[96 + 32*i +: 32];
            end
            st_reg <= st_fl;
            sq_reg <= '0;
            pos_reg <= '0;
            neg_reg <= '0;
        end
        unique case (cmd.state)
            ST_OMEGA: if (ddone)
                omega_reg <= (dquo > 96'h7fffffff) ? 32'sh7fffffff : dquo[31:0];
            ST_X: x_reg <= qmul(omega_reg, 32'(delta_time));
            ST_X2: x2_reg <= qmul(x_reg, x_reg);
            ST_X3: x3_reg <= qmul(x2_reg, x_reg);
            ST_DEN1: a_reg <= qmul(C048, x2_reg);
            ST_DEN2: begin
                b_reg <= qmul(C0235, x3_reg);
                den_reg <= sat32(66'(ONE_C) + 66'(x_reg) + 66'(a_reg)
                    + 66'(qmul(C0235, x3_reg)));
            end
            ST_EXP: if (ddone) ex_reg <= dquo[31:0];
            ST_CHG: chg_reg[c] <= d1;
            ST_SQ: sq_reg <= sq_reg + 66'(64'(mch) * 64'(mch));
            ST_MC: mc_reg <= qmul(32'(max_speed), 32'(st_reg));
            ST_MC2: mc2_reg <= 64'(mc_reg) * 64'(mc_reg);
            ST_SQRT: if (qdone) len_reg <= qroot;
            ST_CLAMP: begin
                if (len_reg <= 33'(EPS_Q)) chg_reg[c] <= '0;
                else if (ddone) begin
                    if (chg_reg[c][31])
                        chg_reg[c] <= (dquo > 96'h7fffffff) ? -32'sh7fffffff
                            : 32'(-dquo[31:0]);
                    else
                        chg_reg[c] <= (dquo > 96'h7fffffff) ? 32'sh7fffffff : dquo[31:0];
                end
            end
            ST_T1: a_reg <= sat32(66'(vel_reg[c]) + 66'(qmul(omega_reg, chg_reg[c])));
            ST_T2: tmp_reg <= qmul(a_reg, 32'(delta_time));
            ST_V1: a_reg <= sat32(66'(vel_reg[c]) - 66'(qmul(omega_reg, tmp_reg)));
            ST_V2: begin
                nvel_reg[c] <= qmul(a_reg, ex_reg);
                b_reg <= sat32(66'(chg_reg[c]) + 66'(tmp_reg));
            end
            ST_R1: a_reg <= qmul(b_reg, ex_reg);
            ST_R2: res_reg[c] <= sat32(66'(sat32(66'(cur_reg[c]) - 66'(chg_reg[c])))
                + 66'(a_reg));
            ST_DOT: if (ta != 0 && tb != 0) begin
                if (ta[32] != tb[32]) neg_reg <= neg_reg + 67'(pab);
                else pos_reg <= pos_reg + 67'(pab);
            end
            ST_FIN: snap_reg <= pos_reg > neg_reg;
            default: ;
        endcase
    end

    assign sts.div_done = ddone;
    assign sts.sqrt_done = qdone;
    assign sts.need_clamp = sq_reg > 66'(mc2_reg);

    assign res_data = {snap_reg,
        snap_reg ? 32'd0 : nvel_reg[2], snap_reg ? 32'd0 : nvel_reg[1],
        snap_reg ? 32'd0 : nvel_reg[0],
        snap_reg ? tgt_reg[2] : res_reg[2], snap_reg ? tgt_reg[1] : res_reg[1],
        snap_reg ? tgt_reg[0] : res_reg[0]};

    `CDVS_ASSERT_IMP(a_div_sel, aclk, aresetn, cmd.div_start, cmd.div_sel != DIV_NONE)
    `CDVS_ASSERT_NXT(a_sqrt_busy, aclk, aresetn, cmd.sqrt_start, !qdone)
    `CDVS_ASSERT_IMP(a_one_start, aclk, aresetn, cmd.sqrt_start, !cmd.div_start)
endmodule

[sv/cdvs_ctrl.sv]
// Controller state machine that sequences the datapath.
module cdvs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           out_free,
    input  cdvs_pkg::sts_t sts,
    output cdvs_pkg::cmd_t cmd,
    output logic           busy,
    output logic           result_ready
);
    import cdvs_pkg::*;
    `include "critically_damped_vector_smoother_macros.svh"
    state_t state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic pend_reg, pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            comp_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            comp_reg <= comp_next;
            pend_reg <= pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        comp_next = comp_reg;
        pend_next = pend_reg;
        cmd = '0;
        cmd.state = state_reg;
        cmd.comp = comp_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) begin
                cmd.load = 1'b1;
                state_next = ST_OMEGA;
                pend_next = 1'b1;
            end
            ST_OMEGA: begin
                cmd.div_sel = DIV_OMEGA;
                cmd.div_start = pend_reg;
                pend_next = 1'b0;
                if (sts.div_done) state_next = ST_X;
            end
            ST_X: state_next = ST_X2;
            ST_X2: state_next = ST_X3;
            ST_X3: state_next = ST_DEN1;
            ST_DEN1: state_next = ST_DEN2;
            ST_DEN2: begin
                state_next = ST_EXP;
                pend_next = 1'b1;
            end
            ST_EXP: begin
                cmd.div_sel = DIV_EXP;
                cmd.div_start = pend_reg;
                pend_next = 1'b0;
                if (sts.div_done) begin
                    state_next = ST_CHG;
                    comp_next = 2'd0;
                end
            end
            ST_CHG: state_next = ST_SQ;
            ST_SQ: begin
                if (comp_reg == 2'd2) begin
                    state_next = ST_MC;
                    comp_next = 2'd0;
                end else begin
                    state_next = ST_CHG;
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_MC: state_next = ST_MC2;
            ST_MC2: state_next = ST_CMP;
            ST_CMP: begin
                if (sts.need_clamp) begin
                    state_next = ST_SQRT;
                    pend_next = 1'b1;
                end else state_next = ST_T1;
            end
            ST_SQRT: begin
                cmd.sqrt_start = pend_reg;
                pend_next = 1'b0;
                if (sts.sqrt_done) begin
                    state_next = ST_CLAMP;
                    pend_next = 1'b1;
                end
            end
            ST_CLAMP: begin
                cmd.div_sel = DIV_CLAMP;
                cmd.div_start = pend_reg;
                pend_next = 1'b0;
                if (sts.div_done) begin
                    pend_next = 1'b1;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_T1;
                        comp_next = 2'd0;
                    end else comp_next = comp_reg + 2'd1;
                end
            end
            ST_T1: state_next = ST_T2;
            ST_T2: state_next = ST_V1;
            ST_V1: state_next = ST_V2;
            ST_V2: state_next = ST_R1;
            ST_R1: state_next = ST_R2;
            ST_R2: state_next = ST_DOT;
            ST_DOT: begin
                if (comp_reg == 2'd2) begin
                    state_next = ST_FIN;
                    comp_next = 2'd0;
                end else begin
                    state_next = ST_T1;
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT: if (out_free) begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = state_reg != ST_IDLE;
    assign result_ready = state_reg == ST_OUT && out_free;

    `CDVS_ASSERT_IMP(a_load_idle, aclk, aresetn, cmd.load, state_reg == ST_IDLE)
    `CDVS_ASSERT_NXT(a_commit_idle, aclk, aresetn, cmd.commit, state_reg == ST_IDLE)
    `CDVS_ASSERT_IMP(a_comp_range, aclk, aresetn, 1'b1, comp_reg != 2'd3)
endmodule

[sv/critically_damped_vector_smoother.sv]
// An item's result reaches the output register after the omega and decay divides and the
// per-component steps. A clamped offset adds a square root and three divides.
// One item is worked at a time; the next is accepted in the cycle after the result moves to
// the output register, so output stalls delay the next item.
// Reset (aresetn low, synchronous) clears the velocity, control state and registers to
// smooth_time 1.0, max_speed 2^31-1 LSB and delta_time 1092 LSB.
module critically_damped_vector_smoother (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, speed_x, speed_y, speed_z, snapped, zero fill
    output logic [199:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import cdvs_pkg::*;
    logic [30:0] smooth_time_reg, max_speed_reg, delta_time_reg;
    logic m_valid_reg;
    logic [192:0] m_data_reg;
    logic [192:0] res_data;
    cmd_t cmd;
    sts_t sts;
    logic busy, result_ready, in_fire, out_free;

    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_time_reg <= 31'd65536;
            max_speed_reg <= 31'h7fffffff;
            delta_time_reg <= 31'd1092;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SMOOTH_TIME: smooth_time_reg <= cfg_data[30:0];
                    REG_MAX_SPEED: max_speed_reg <= cfg_data[30:0];
                    REG_DELTA_TIME: delta_time_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (result_ready) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
        if (result_ready) m_data_reg <= res_data;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_data_reg};

    cdvs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .cmd(cmd), .busy(busy), .result_ready(result_ready)
    );

    cdvs_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .in_data(s_tdata),
        .smooth_time(smooth_time_reg), .max_speed(max_speed_reg),
        .delta_time(delta_time_reg), .res_data(res_data)
    );
endmodule
